// ----- design/h2b_pkg.sv -----
// Shared types, constants and character functions for the hex to base64 transcoder.
package h2b_pkg;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int MAX_CHARS = 4;
	localparam int NCH_W = $clog2(MAX_CHARS + 1);
	localparam int CIDX_W = $clog2(MAX_CHARS);

	localparam logic [7:0] PAD_CHAR = 8'h3D;
	localparam logic [7:0] CHAR_UA = 8'h41;
	localparam logic [7:0] CHAR_UF = 8'h46;
	localparam logic [7:0] CHAR_LA = 8'h61;
	localparam logic [7:0] CHAR_ZERO = 8'h30;
	localparam logic [7:0] CHAR_PLUS = 8'h2B;
	localparam logic [7:0] CHAR_SLASH = 8'h2F;

	typedef enum logic [1:0] {
		PH_FIRST = 2'd0,
		PH_SECOND = 2'd1,
		PH_THIRD = 2'd2
	} phase_t;

	typedef struct packed {
		logic [7:0] hex_char;
		logic       final_char;
	} in_t;

	typedef struct packed {
		logic [7:0] b64_char;
		logic       last_out;
	} out_t;

	typedef struct packed {
		logic [NCH_W-1:0]             n_chars;
		logic [MAX_CHARS-1:0][7:0]    chars;
		logic                         last;
	} job_t;

	function automatic logic [7:0] sextet_char(input logic [5:0] v);
		logic [7:0] w;
		w = {2'b00, v};
		if (v < 6'd26) begin
			return CHAR_UA + w;
		end else if (v < 6'd52) begin
			return CHAR_LA + w - 8'd26;
		end else if (v < 6'd62) begin
			return CHAR_ZERO + w - 8'd52;
		end else if (v == 6'd62) begin
			return CHAR_PLUS;
		end
		return CHAR_SLASH;
	endfunction

	function automatic logic [3:0] digit_value(input logic [7:0] c);
		logic [7:0] d;
		if (c >= CHAR_UA && c <= CHAR_UF) begin
			d = c - CHAR_UA + 8'd10;
		end else begin
			d = c - CHAR_ZERO;
		end
		return d[3:0];
	endfunction

endpackage

// ----- design/h2b_front.sv -----
// Front end: accepts hex digits, tracks group position and builds character jobs.
module h2b_front
	import h2b_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  in_t  req,
	input  logic req_valid,
	input  logic queue_full,
	output logic req_stall,
	output logic push,
	output job_t push_job
);

	phase_t     phase_q;
	logic [5:0] carry_q;
	logic [1:0] cnt_q;

	phase_t           nphase;
	logic [5:0]       ncarry;
	logic             has_c0;
	logic [7:0]       c0;
	logic [3:0]       v;
	logic [NCH_W-1:0] n;
	logic [1:0]       tail;
	logic             accept;

	assign req_stall = queue_full;
	assign accept = req_valid && !queue_full;
	assign v = digit_value(req.hex_char);

	always_comb begin
		case (phase_q)
			PH_SECOND: begin
				has_c0 = 1'b1;
				c0 = sextet_char(carry_q | {4'b0000, v[3:2]});
				ncarry = {v[1:0], 4'b0000};
				nphase = PH_THIRD;
			end
			PH_THIRD: begin
				has_c0 = 1'b1;
				c0 = sextet_char(carry_q | {2'b00, v});
				ncarry = 6'd0;
				nphase = PH_FIRST;
			end
			default: begin
				has_c0 = 1'b0;
				c0 = CHAR_UA;
				ncarry = {v, 2'b00};
				nphase = PH_SECOND;
			end
		endcase
	end

	always_comb begin
		push_job.chars = '{default: PAD_CHAR};
		n = '0;
		if (has_c0) begin
			push_job.chars[n[CIDX_W-1:0]] = c0;
			n = n + NCH_W'(1);
		end
		if (req.final_char && nphase != PH_FIRST) begin
			push_job.chars[n[CIDX_W-1:0]] = sextet_char(ncarry);
			n = n + NCH_W'(1);
		end
		tail = cnt_q + n[1:0];
		if (req.final_char && tail == 2'd2) begin
			n = n + NCH_W'(2);
		end else if (req.final_char && tail == 2'd3) begin
			n = n + NCH_W'(1);
		end
		push_job.n_chars = n;
		push_job.last = req.final_char;
	end

	assign push = accept && (n != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_FIRST;
			carry_q <= 6'd0;
			cnt_q <= 2'd0;
		end else if (accept) begin
			if (req.final_char) begin
				phase_q <= PH_FIRST;
				carry_q <= 6'd0;
				cnt_q <= 2'd0;
			end else begin
				phase_q <= nphase;
				carry_q <= ncarry;
				cnt_q <= tail;
			end
		end
	end

endmodule

// ----- design/h2b_queue.sv -----
// Short job queue that decouples the front end from the character sender.
module h2b_queue
	import h2b_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_job,
	input  logic pop,
	output logic full,
	output logic head_valid,
	output job_t head_job
);

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head_job = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

endmodule

// ----- design/h2b_back.sv -----
// Back end: sends the characters of each queued job through the output register.
module h2b_back
	import h2b_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic head_valid,
	input  job_t head_job,
	output logic pop,
	output out_t rsp,
	output logic rsp_valid,
	input  logic rsp_stall
);

	logic [CIDX_W-1:0] idx_q;
	logic              out_valid_q;
	out_t              out_q;
	logic              adv;
	logic              at_end;

	assign adv = !out_valid_q || !rsp_stall;
	assign at_end = ({1'b0, idx_q} == head_job.n_chars - NCH_W'(1));
	assign pop = adv && head_valid && at_end;
	assign rsp = out_q;
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk) begin
		if (adv && head_valid) begin
			out_q.b64_char <= head_job.chars[idx_q];
			out_q.last_out <= head_job.last && at_end;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= head_valid;
			if (head_valid) begin
				idx_q <= at_end ? '0 : idx_q + CIDX_W'(1);
			end
		end
	end

endmodule

// ----- design/hex_to_base64_transcoder_core.sv -----
// Top level of the hex to base64 transcoder.
// Path: each job is queued, then its characters go through the output register.
// Throughput: one request per cycle while req_stall is low, one character per cycle
// at the output while rsp_stall is low; a final job holds up to four characters.
// Reset: arst_n clears the group position, leftover bits, counters and queue.
module hex_to_base64_transcoder_core
	import h2b_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  in_t  req,
	input  logic req_valid,
	output logic req_stall,
	output out_t rsp,
	output logic rsp_valid,
	input  logic rsp_stall
);

	logic push;
	job_t push_job;
	logic pop;
	logic queue_full;
	logic head_valid;
	job_t head_job;

	h2b_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.req_valid  (req_valid),
		.queue_full (queue_full),
		.req_stall  (req_stall),
		.push       (push),
		.push_job   (push_job)
	);

	h2b_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.pop        (pop),
		.full       (queue_full),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	h2b_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.rsp        (rsp),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall)
	);

`ifndef SYNTHESIS
	a_final_pushes: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall && req.final_char) |-> push)
		else $error("final request produced no job");

	a_stall_has_jobs: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> head_valid)
		else $error("request stalled with an empty queue");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> (head_valid && (!rsp_valid || !rsp_stall)))
		else $error("job retired without a free output slot");

	a_job_size: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_job.n_chars <= NCH_W'(MAX_CHARS)))
		else $error("job holds too many characters");
`endif

endmodule
